### sv/ssnf_pkg.sv
// Shared types, constants and lookup functions of the seven-segment number formatter.
package ssnf_pkg;

    localparam int unsigned VALUE_W = 20;
    localparam int unsigned DIGITS  = 6;
    localparam int unsigned SLOTS   = 4;

    // ceil(2^23 / 10); floor(x * RECIP10 >> 23) == x / 10 for x < 2^22
    localparam logic [19:0] RECIP10 = 20'd838861;
    localparam int unsigned RECIP_SHIFT = 23;

    localparam logic [1:0] UNIT_NONE = 2'd0;
    localparam logic [1:0] UNIT_C    = 2'd1;
    localparam logic [1:0] UNIT_F    = 2'd2;

    localparam logic [1:0] PREC_MAX  = 2'd2;

    localparam logic [7:0] SEG_BLANK    = 8'h00;
    localparam logic [7:0] SEG_POINT    = 8'h80;
    localparam logic [7:0] SEG_LETTER_C = 8'h39;
    localparam logic [7:0] SEG_LETTER_F = 8'h71;

    localparam logic [1:0] LAST_SLOT = 2'd3;

    typedef struct packed {
        logic [19:0] value_hundredths;
        logic [1:0]  fraction_digits;
        logic [1:0]  unit_symbol;
    } ssnf_in_t;

    typedef struct packed {
        logic [3:0] ram_address;
        logic [7:0] segment_byte;
        logic       last_digit;
    } ssnf_out_t;

    // One item in the digit pipeline: running quotient, digits shifted in
    // from the top (digit 0 lands at index 0 after all stages), and a
    // nonzero flag per quotient.
    typedef struct packed {
        logic [VALUE_W-1:0]           quo;
        logic [DIGITS-1:0][3:0]       digits;
        logic [DIGITS-1:0]            nz;
        logic [1:0]                   prec;
        logic [1:0]                   unit;
    } ssnf_pipe_t;

    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h67;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

    // Display RAM byte address per slot; the colon at address 4 is skipped.
    function automatic logic [3:0] slot_address(input logic [1:0] slot);
        logic [3:0] a;
        case (slot)
            2'd0:    a = 4'd8;
            2'd1:    a = 4'd6;
            2'd2:    a = 4'd2;
            default: a = 4'd0;
        endcase
        return a;
    endfunction

endpackage

### sv/ssnf_div10_stage.sv
// One pipeline stage: divide the running quotient by ten and shift out one decimal digit.
module ssnf_div10_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   up_valid,
    input  ssnf_pkg::ssnf_pipe_t   up,
    output logic                   dn_valid,
    output ssnf_pkg::ssnf_pipe_t   dn
);

    logic [39:0]                 prod;
    logic [ssnf_pkg::VALUE_W-1:0] quo;
    logic [ssnf_pkg::VALUE_W-1:0] rem_wide;
    logic                        valid_reg;
    logic                        valid_next;
    ssnf_pkg::ssnf_pipe_t        data_reg;
    ssnf_pkg::ssnf_pipe_t        data_next;

    always_comb
    begin
        prod      = {20'd0, up.quo} * {20'd0, ssnf_pkg::RECIP10};
        quo       = {3'b000, prod[39:ssnf_pkg::RECIP_SHIFT]};
        rem_wide  = up.quo - {quo[16:0], 3'b000} - {quo[18:0], 1'b0};
        data_next        = up;
        data_next.quo    = quo;
        data_next.digits = {rem_wide[3:0], up.digits[ssnf_pkg::DIGITS-1:1]};
        data_next.nz     = {(quo != '0), up.nz[ssnf_pkg::DIGITS-1:1]};
        valid_next       = up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;

endmodule

### sv/ssnf_serializer.sv
// Formats the four segment bytes of an item and sends them out one digit beat at a time.
module ssnf_serializer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_valid,
    input  ssnf_pkg::ssnf_pipe_t   load,
    output logic                   take,
    output logic                   digit_valid,
    input  logic                   digit_stall,
    output ssnf_pkg::ssnf_out_t    digit
);

    logic                                   busy_reg;
    logic                                   busy_next;
    logic [1:0]                             slot_reg;
    logic [1:0]                             slot_next;
    logic [ssnf_pkg::SLOTS-1:0][7:0]        segs_reg;
    logic [ssnf_pkg::SLOTS-1:0][7:0]        segs_next;
    logic [2:0]                             idx;
    logic [2:0]                             prec3;

    // segment byte per slot, slot 0 rightmost
    always_comb
    begin
        prec3 = {1'b0, load.prec};
        for (int k = 0; k < ssnf_pkg::SLOTS; k++)
        begin
            idx = 3'(k) + 3'd2 - prec3;
            if (3'(k) >= prec3 && !load.nz[idx - 3'd1])
                segs_next[k] = ssnf_pkg::SEG_BLANK;
            else
                segs_next[k] = ssnf_pkg::glyph(load.digits[idx]);
        end
        if (load.unit == ssnf_pkg::UNIT_C)
            segs_next[0] = ssnf_pkg::SEG_LETTER_C;
        else if (load.unit == ssnf_pkg::UNIT_F)
            segs_next[0] = ssnf_pkg::SEG_LETTER_F;
        segs_next[load.prec] = segs_next[load.prec] | ssnf_pkg::SEG_POINT;
    end

    assign take = !busy_reg || (slot_reg == ssnf_pkg::LAST_SLOT && !digit_stall);

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (take)
        begin
            busy_next = load_valid;
            slot_next = 2'd0;
        end
        else if (!digit_stall)
        begin
            slot_next = slot_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            segs_reg <= segs_next;
        end
    end

    assign digit_valid        = busy_reg;
    assign digit.ram_address  = ssnf_pkg::slot_address(slot_reg);
    assign digit.segment_byte = segs_reg[slot_reg];
    assign digit.last_digit   = (slot_reg == ssnf_pkg::LAST_SLOT);

endmodule

### sv/seven_segment_number_formatter_core.sv
// Top level: value in hundredths to four seven-segment digit writes.
// Path: an accepted item passes the six divide stages, then loads into the output register.
// The item rate is set by the four digit beats on the output, which digit_stall can hold;
//   the six divide stages take a new item every cycle unless the output holds the last one.
// Reset: rst_n async, active low, empties all stages and the output register.
module seven_segment_number_formatter_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  ssnf_pkg::ssnf_in_t    item,
    output logic                  digit_valid,
    input  logic                  digit_stall,
    output ssnf_pkg::ssnf_out_t   digit
);

    // Stage chain: stage 0 is the incoming beat, stages 1..6 each peel one
    // decimal digit (hundredths, tenths, ones, tens, hundreds, thousands).
    logic [ssnf_pkg::DIGITS:0]                 sv_valid;
    ssnf_pkg::ssnf_pipe_t [ssnf_pkg::DIGITS:0] sv_data;
    logic                                      take;
    logic                                      adv;

    // Whole pipe moves together; it holds only while the last stage has an
    // item that the serializer cannot yet take.
    assign adv        = take || !sv_valid[ssnf_pkg::DIGITS];
    assign item_stall = !adv;

    assign sv_valid[0]        = item_valid;
    assign sv_data[0].quo     = item.value_hundredths;
    assign sv_data[0].digits  = '0;
    assign sv_data[0].nz      = '0;
    // fraction count three saturates to two
    assign sv_data[0].prec    = (item.fraction_digits > ssnf_pkg::PREC_MAX) ?
                                ssnf_pkg::PREC_MAX : item.fraction_digits;
    // unit code three falls through as no unit in the formatter
    assign sv_data[0].unit    = item.unit_symbol;

    for (genvar s = 0; s < ssnf_pkg::DIGITS; s++)
    begin : g_stage
        ssnf_div10_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .up_valid (sv_valid[s]),
            .up       (sv_data[s]),
            .dn_valid (sv_valid[s+1]),
            .dn       (sv_data[s+1])
        );
    end

    // Formatting (blanking, point, unit letter) happens on load into the
    // output register; beats then leave rightmost digit first.
    ssnf_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (sv_valid[ssnf_pkg::DIGITS]),
        .load        (sv_data[ssnf_pkg::DIGITS]),
        .take        (take),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit)
    );

endmodule

### tb/seven_segment_number_formatter_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the seven-segment number formatter core.
module seven_segment_number_formatter_core_tb;

    // Codes outside the documented range; the core saturates or ignores them.
    localparam logic [1:0] PREC_OVER     = 2'd3;
    localparam logic [1:0] UNIT_RESERVED = 2'd3;

    // Idle time after the last owed digit has arrived; allows some margin.
    localparam int unsigned DRAIN_CYCLES = 16;
    // Several times what the slowest run needs.
    localparam int unsigned RUN_LIMIT_NS = 3_000_000;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    ssnf_pkg::ssnf_in_t  item;
    logic                digit_valid;
    logic                digit_stall;
    ssnf_pkg::ssnf_out_t digit;

    // Digit writes still owed by the core, oldest first.
    ssnf_pkg::ssnf_out_t pending_digits[$];
    int                  mismatch_count;
    // When set, neither side inserts gaps or stalls.
    bit                  idle_off;

    seven_segment_number_formatter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Segment pattern a..g of a decimal numeral.
    function automatic logic [7:0] numeral_segments(input int unsigned n);
        logic [7:0] s;
        case (n)
            0:       s = 8'h3F;
            1:       s = 8'h06;
            2:       s = 8'h5B;
            3:       s = 8'h4F;
            4:       s = 8'h66;
            5:       s = 8'h6D;
            6:       s = 8'h7D;
            7:       s = 8'h07;
            8:       s = 8'h7F;
            default: s = 8'h67;
        endcase
        return s;
    endfunction

    // Display RAM address of a digit position counted from the right.
    function automatic logic [3:0] position_ram_address(input int unsigned pos);
        logic [3:0] a;
        case (pos)
            0:       a = 4'd8;
            1:       a = 4'd6;
            2:       a = 4'd2;
            default: a = 4'd0;
        endcase
        return a;
    endfunction

    // Works out the four digit writes of one reading and queues them,
    // rightmost digit first.
    function automatic void queue_digit_writes(input ssnf_pkg::ssnf_in_t rd);
        int unsigned         whole;
        int unsigned         cents;
        int unsigned         prec;
        logic [7:0]          seg [4];
        ssnf_pkg::ssnf_out_t w;

        whole = rd.value_hundredths / 100;
        cents = rd.value_hundredths % 100;
        // A fraction count of three saturates to two.
        prec  = (rd.fraction_digits > ssnf_pkg::PREC_MAX) ?
                ssnf_pkg::PREC_MAX : rd.fraction_digits;

        for (int k = 0; k < 4; k++)
        begin
            seg[k] = ssnf_pkg::SEG_BLANK;
        end

        // Fraction digits are truncated: tenths sit just right of the point.
        if (prec == 2)
        begin
            seg[1] = numeral_segments(cents / 10);
            seg[0] = numeral_segments(cents % 10);
        end
        else if (prec == 1)
        begin
            seg[0] = numeral_segments(cents / 10);
        end

        // Integer digits, ones first; once the integer part is used up the
        // position stays blank, so a zero integer part blanks the ones digit.
        // Digits beyond the leftmost position simply fall off.
        for (int k = prec; k < 4; k++)
        begin
            if (whole != 0)
            begin
                seg[k] = numeral_segments(whole % 10);
                whole  = whole / 10;
            end
        end

        // Unit letter overrides the rightmost glyph; the reserved code does not.
        if (rd.unit_symbol == ssnf_pkg::UNIT_C)
            seg[0] = ssnf_pkg::SEG_LETTER_C;
        else if (rd.unit_symbol == ssnf_pkg::UNIT_F)
            seg[0] = ssnf_pkg::SEG_LETTER_F;

        // Point goes on the digit whose index equals the fraction count,
        // which puts it on the rightmost digit when there is no fraction.
        seg[prec] = seg[prec] | ssnf_pkg::SEG_POINT;

        for (int k = 0; k < 4; k++)
        begin
            w.ram_address  = position_ram_address(k);
            w.segment_byte = seg[k];
            w.last_digit   = (k == 3);
            pending_digits.push_back(w);
        end
    endfunction

    // Sends one reading: optional idle gap, then hold valid until the core
    // takes the beat. Valid is left high so a zero gap gives back-to-back beats.
    task automatic send_reading(input logic [19:0] value, input logic [1:0] prec,
                                input logic [1:0] unit);
        int unsigned        gap;
        ssnf_pkg::ssnf_in_t rd;

        gap = idle_off ? 0 : $urandom_range(0, 8);
        rd.value_hundredths = value;
        rd.fraction_digits  = prec;
        rd.unit_symbol      = unit;

        @(negedge clk);
        repeat (gap)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= rd;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        queue_digit_writes(rd);
    endtask

    // Random value: mostly in range, some small ones where blanking matters,
    // some across all 20 bits (above range), some whole numbers.
    function automatic logic [19:0] random_value();
        logic [19:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = 20'($urandom_range(0, 999));
            3, 4, 5: v = 20'($urandom_range(0, 999999));
            6, 7:    v = 20'($urandom_range(0, 20'hFFFFF));
            default: v = 20'($urandom_range(0, 9999) * 100);
        endcase
        return v;
    endfunction

    // Lets the core empty out before the sender continues.
    task automatic wait_for_drain();
        @(negedge clk);
        item_valid <= 1'b0;
        wait (pending_digits.size() == 0);
    endtask

    // Range edges of the value, including the largest 20-bit code, and
    // alternating bit patterns.
    task automatic test_field_extremes();
        send_reading(20'd0,       2'd0, ssnf_pkg::UNIT_NONE);
        send_reading(20'd0,       2'd2, ssnf_pkg::UNIT_NONE);
        send_reading(20'd1,       2'd2, ssnf_pkg::UNIT_NONE);
        send_reading(20'd99,      2'd1, ssnf_pkg::UNIT_NONE);
        send_reading(20'd100,     2'd0, ssnf_pkg::UNIT_NONE);
        send_reading(20'd999999,  2'd0, ssnf_pkg::UNIT_NONE);
        send_reading(20'd999999,  2'd2, ssnf_pkg::UNIT_F);
        send_reading(20'hFFFFF,   2'd0, ssnf_pkg::UNIT_NONE);
        send_reading(20'h55555,   2'd1, ssnf_pkg::UNIT_C);
        send_reading(20'hAAAAA,   PREC_OVER, UNIT_RESERVED);
    endtask

    // Every fraction count against every unit code, including the
    // saturated count and the reserved unit.
    task automatic test_precision_and_units();
        for (int p = 0; p < 4; p++)
        begin
            for (int u = 0; u < 4; u++)
            begin
                send_reading(20'd12345, p[1:0], u[1:0]);
            end
        end
    endtask

    // Full-rate traffic on both sides: no gaps, no stalls.
    task automatic test_back_to_back();
        idle_off = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            send_reading(random_value(), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)));
        end
        wait_for_drain();
        idle_off = 1'b0;
    endtask

    // Random readings with random idling; every so often the sender waits
    // until the core has handed out every digit.
    task automatic test_random_readings();
        for (int i = 0; i < 310; i++)
        begin
            if (i % 64 == 63)
                wait_for_drain();
            send_reading(random_value(), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)));
        end
    endtask

    // Digit side: random stall before each beat, then check what arrives.
    initial
    begin
        int unsigned         hold;
        ssnf_pkg::ssnf_out_t want;

        digit_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            hold = idle_off ? 0 : $urandom_range(0, 8);
            repeat (hold)
            begin
                digit_stall <= 1'b1;
                @(negedge clk);
            end
            digit_stall <= 1'b0;
            do
                @(posedge clk);
            while (!digit_valid);

            if (pending_digits.size() == 0)
            begin
                $display("%0t: unexpected digit beat, expected none actual %h",
                         $time, digit);
                mismatch_count++;
            end
            else
            begin
                want = pending_digits.pop_front();
                if (digit.ram_address !== want.ram_address)
                begin
                    $display("%0t: ram_address expected %0d actual %0d",
                             $time, want.ram_address, digit.ram_address);
                    mismatch_count++;
                end
                if (digit.segment_byte !== want.segment_byte)
                begin
                    $display("%0t: segment_byte expected %h actual %h",
                             $time, want.segment_byte, digit.segment_byte);
                    mismatch_count++;
                end
                if (digit.last_digit !== want.last_digit)
                begin
                    $display("%0t: last_digit expected %b actual %b",
                             $time, want.last_digit, digit.last_digit);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop in case the core hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        idle_off       = 1'b0;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_precision_and_units();
        test_back_to_back();
        test_random_readings();

        // Stimulus done: let every owed digit arrive, then a few idle cycles.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_digits.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
sv/ssnf_pkg.sv
sv/ssnf_div10_stage.sv
sv/ssnf_serializer.sv
sv/seven_segment_number_formatter_core.sv
tb/seven_segment_number_formatter_core_tb.sv
